// File: hdl/packet_header_classifier_counter_assert.svh
// Assertion macros shared by the packet header classifier counter RTL.
`ifndef PACKET_HEADER_CLASSIFIER_COUNTER_ASSERT_SVH
`define PACKET_HEADER_CLASSIFIER_COUNTER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define PHCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define PHCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/phcc_pkg.sv
// Package with constants, types and helpers of the packet header classifier counter.
`timescale 1ns / 1ps

package phcc_pkg;

    // Default build values of the top level parameters.
    localparam int MAX_TAGS_DEF   = 2;
    localparam int COUNT_BITS_DEF = 32;

    // Protocol constants.
    localparam logic [15:0] TPID_CTAG      = 16'h8100;
    localparam logic [15:0] TPID_STAG      = 16'h88A8;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  ICMP_PING_TYPE = 8'd8;
    localparam logic        VERDICT_PASS   = 1'b0;
    localparam logic        VERDICT_DROP   = 1'b1;

    // Header geometry.
    localparam int ETH_LEN     = 14;
    localparam int ETH_TYPE_HI = 12;
    localparam int ETH_TYPE_LO = 13;
    localparam int VLAN_LEN    = 4;
    localparam int IP_MIN_LEN  = 20;
    localparam int IP_PROTO_OFS = 9;
    localparam int L4_KEEP     = 8;
    localparam int TCP_MIN_LEN = 20;
    localparam int TCP_OFS_POS = 12;
    localparam int HDR_WORDS_MIN = 5;

    // Width of frame length arithmetic (lengths up to 256).
    localparam int EVAL_W = 9;

    // Class counters.
    localparam int NUM_CLASSES = 5;
    localparam int CNT_OUT_W   = 32;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FLAG_W  = 1 + NUM_CLASSES;
    localparam int OUT_RAW_W   = OUT_FLAG_W + NUM_CLASSES * CNT_OUT_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    // Configuration port.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_DROP_PARITY = 2'd0;

    // Class hits of one frame, vlan in the lowest bit.
    typedef struct packed {
        logic tcp;
        logic udp;
        logic icmp;
        logic ipv4;
        logic vlan;
    } t_hits;

    // True for the two VLAN tag protocol identifiers.
    function automatic logic is_vlan(input logic [15:0] etype);
        return (etype == TPID_CTAG) || (etype == TPID_STAG);
    endfunction

endpackage

// File: hdl/packet_header_classifier_counter.sv
// Top level of the packet header classifier counter.
`timescale 1ns / 1ps
`include "packet_header_classifier_counter_assert.svh"

// Parses Ethernet, up to MAX_TAGS VLAN tags, IPv4 and ICMP echo, UDP or TCP from a byte
// stream, one byte per cycle while ready is high, with tlast on the final byte; a frame
// of any length may follow the previous one directly. Each last byte produces one result
// request holding the verdict, the class hits and all five class counts after that frame.
// The counts live in a one-entry counter memory read on the last byte and written back
// from the counter stage, with the previous write forwarded, so one frame per cycle is
// sustained while the output is not stalled. Input ready drops only while a finished
// result sits in the counter stage and another waits unaccepted at the output. After
// reset the counters read as zero through a valid flag: no clearing pass.
module packet_header_classifier_counter #(
    parameter int MAX_TAGS   = phcc_pkg::MAX_TAGS_DEF,
    parameter int COUNT_BITS = phcc_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Byte stream in.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [phcc_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // [7:0] frame_byte
    input  logic                                i_s_tlast,  // is_last
    // Result stream out.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // From bit 0: verdict, hit_vlan, hit_ipv4, hit_icmp, hit_udp, hit_tcp,
    // vlan_count, ipv4_count, icmp_count, udp_count, tcp_count (32 each), zero pad.
    output logic [phcc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [phcc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [phcc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [phcc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    import phcc_pkg::*;

    localparam int TAG_W  = (MAX_TAGS > 0) ? $clog2(MAX_TAGS + 1) : 1;
    localparam int IPS_W  = $clog2(ETH_LEN + VLAN_LEN * MAX_TAGS + 1);
    localparam int CNT_W  = NUM_CLASSES * COUNT_BITS;
    localparam logic [TAG_W-1:0] TAG_LIMIT = TAG_W'(MAX_TAGS);
    localparam logic [IPS_W-1:0] IPS_RESET = IPS_W'(ETH_LEN);
    localparam logic [IPS_W-1:0] IPS_LIMIT = IPS_W'(ETH_LEN + VLAN_LEN * MAX_TAGS);

    // Configuration register.
    logic r_drop_parity;
    logic cfg_wr;

    // Per-frame parse state.
    logic [7:0]       r_pos,        n_pos;
    logic [15:0]      r_outer_type, n_outer_type;
    logic [15:0]      r_chain_type, n_chain_type;
    logic [7:0]       r_tag_inner,  n_tag_inner;
    logic [TAG_W-1:0] r_tags,       n_tags;
    logic [IPS_W-1:0] r_ip_start,   n_ip_start;
    logic [3:0]       r_ihl,        n_ihl;
    logic [7:0]       r_proto,      n_proto;
    logic [7:0][7:0]  r_l4,         n_l4;
    logic [3:0]       r_tcp_off,    n_tcp_off;

    // Frame classification of the byte at the input.
    t_hits cls_hits;
    logic  cls_verdict;

    // Counter stage.
    logic  s_accept;
    logic  last_accept;
    logic  s1_adv;
    logic  r_s1_valid;
    t_hits r_s1_hits;
    logic  r_s1_verdict;
    logic  r_s1_fwd;
    logic  r_s1_zero;
    logic  r_cnt_valid;
    logic  cnt_wr;
    logic [CNT_W-1:0] ram_rd_data;
    logic [CNT_W-1:0] r_wr_data;
    logic [NUM_CLASSES-1:0][COUNT_BITS-1:0] cnt_base;
    logic [NUM_CLASSES-1:0][COUNT_BITS-1:0] cnt_new;
    logic [OUT_TDATA_W-1:0] n_out_data;

    // Output register.
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    // Configuration access: writes land on psel, penable and pwrite.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == REG_DROP_PARITY) ? APB_DATA_W'(r_drop_parity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_parity <= 1'b0;
        end else if (cfg_wr && (paddr == REG_DROP_PARITY)) begin
            r_drop_parity <= pwdata[0];
        end
    end

    // Handshakes: the counter stage moves when the output register is empty or being read.
    assign s1_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_s1_valid || s1_adv;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign last_accept = s_accept && i_s_tlast;
    assign cnt_wr      = r_s1_valid && s1_adv;

    // Parse state update for the byte at the input.
    always_comb begin
        logic [7:0]        rel;
        logic [EVAL_W-1:0] l4s;
        logic [EVAL_W-1:0] k;
        logic              tag_mode;

        n_pos        = (r_pos == 8'hFF) ? r_pos : r_pos + 8'd1;
        n_outer_type = r_outer_type;
        n_chain_type = r_chain_type;
        n_tag_inner  = r_tag_inner;
        n_tags       = r_tags;
        n_ip_start   = r_ip_start;
        n_ihl        = r_ihl;
        n_proto      = r_proto;
        n_l4         = r_l4;
        n_tcp_off    = r_tcp_off;

        rel      = r_pos - 8'(r_ip_start);
        tag_mode = (rel < 8'(VLAN_LEN)) && (r_tags < TAG_LIMIT) && is_vlan(r_chain_type);
        l4s      = EVAL_W'(r_ip_start) + EVAL_W'({r_ihl, 2'b00});
        k        = EVAL_W'(r_pos) - l4s;

        if (r_pos == 8'(ETH_TYPE_HI)) begin
            n_outer_type = {i_s_tdata, 8'h00};
        end else if (r_pos == 8'(ETH_TYPE_LO)) begin
            n_outer_type = {r_outer_type[15:8], i_s_tdata};
            n_chain_type = {r_outer_type[15:8], i_s_tdata};
        end else if (r_pos >= 8'(r_ip_start)) begin
            if (tag_mode) begin
                // Tag control bytes are skipped; the inner type chains onward.
                if (rel == 8'd2) begin
                    n_tag_inner = i_s_tdata;
                end else if (rel == 8'd3) begin
                    n_chain_type = {r_tag_inner, i_s_tdata};
                    n_tags       = r_tags + TAG_W'(1);
                    n_ip_start   = r_ip_start + IPS_W'(VLAN_LEN);
                end
            end else begin
                if (rel == 8'd0) begin
                    n_ihl = i_s_tdata[3:0];
                end else if (rel == 8'(IP_PROTO_OFS)) begin
                    n_proto = i_s_tdata;
                end
                // The header length is known from the first IP byte onward.
                if ((r_ihl >= 4'(HDR_WORDS_MIN)) && (EVAL_W'(r_pos) >= l4s)) begin
                    if (k < EVAL_W'(L4_KEEP)) begin
                        n_l4[k[2:0]] = i_s_tdata;
                    end else if (k == EVAL_W'(TCP_OFS_POS)) begin
                        n_tcp_off = i_s_tdata[7:4];
                    end
                end
            end
        end
    end

    // Classification from the state after this byte, used when it is the last.
    always_comb begin
        logic [EVAL_W-1:0] len;
        logic [EVAL_W-1:0] ips;
        logic [EVAL_W-1:0] l4s;
        logic              ip_ok;

        len = EVAL_W'(r_pos) + EVAL_W'(1);
        ips = EVAL_W'(n_ip_start);
        l4s = ips + EVAL_W'({n_ihl, 2'b00});
        ip_ok = (len >= ips + EVAL_W'(IP_MIN_LEN)) && (n_ihl >= 4'(HDR_WORDS_MIN))
             && (len >= l4s);

        cls_hits      = '0;
        cls_verdict   = VERDICT_PASS;
        cls_hits.vlan = (len >= EVAL_W'(ETH_LEN)) && is_vlan(n_outer_type);
        if (ip_ok) begin
            if (n_proto == PROTO_ICMP) begin
                cls_hits.ipv4 = 1'b1;
                if ((len >= l4s + EVAL_W'(L4_KEEP)) && (n_l4[0] == ICMP_PING_TYPE)) begin
                    cls_hits.icmp = 1'b1;
                    if (n_l4[7][0] == r_drop_parity) begin
                        cls_verdict = VERDICT_DROP;
                    end
                end
            end else if (n_proto == PROTO_UDP) begin
                cls_hits.ipv4 = 1'b1;
                cls_hits.udp  = (len >= l4s + EVAL_W'(L4_KEEP))
                             && ({n_l4[4], n_l4[5]} >= 16'(L4_KEEP));
            end else if (n_proto == PROTO_TCP) begin
                cls_hits.ipv4 = 1'b1;
                cls_hits.tcp  = (len >= l4s + EVAL_W'(TCP_MIN_LEN))
                             && (n_tcp_off >= 4'(HDR_WORDS_MIN))
                             && (len >= l4s + EVAL_W'({n_tcp_off, 2'b00}));
            end
        end
    end

    // Parse registers; everything returns to the frame start after a last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || last_accept) begin
            r_pos        <= '0;
            r_outer_type <= '0;
            r_chain_type <= '0;
            r_tag_inner  <= '0;
            r_tags       <= '0;
            r_ip_start   <= IPS_RESET;
            r_ihl        <= '0;
            r_proto      <= '0;
            r_l4         <= '0;
            r_tcp_off    <= '0;
        end else if (s_accept) begin
            r_pos        <= n_pos;
            r_outer_type <= n_outer_type;
            r_chain_type <= n_chain_type;
            r_tag_inner  <= n_tag_inner;
            r_tags       <= n_tags;
            r_ip_start   <= n_ip_start;
            r_ihl        <= n_ihl;
            r_proto      <= n_proto;
            r_l4         <= n_l4;
            r_tcp_off    <= n_tcp_off;
        end
    end

    // Counter memory: read on a last byte, written back from the counter stage.
    phcc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (1)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_wr),
        .i_wr_addr (1'b0),
        .i_wr_data (cnt_new),
        .i_rd_en   (last_accept),
        .i_rd_addr (1'b0),
        .o_rd_data (ram_rd_data)
    );

    // Counter stage: pick forwarded, stored or reset counts and add the hits.
    always_comb begin
        cnt_base = r_s1_zero ? '0 : (r_s1_fwd ? r_wr_data : ram_rd_data);
        for (int c = 0; c < NUM_CLASSES; c++) begin
            cnt_new[c] = cnt_base[c] + COUNT_BITS'(r_s1_hits[c]);
        end
        n_out_data = '0;
        n_out_data[0] = r_s1_verdict;
        n_out_data[OUT_FLAG_W-1:1] = r_s1_hits;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            n_out_data[OUT_FLAG_W + c * CNT_OUT_W +: CNT_OUT_W] = CNT_OUT_W'(cnt_new[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_cnt_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_valid <= i_s_tvalid && i_s_tlast;
            end
            if (cnt_wr) begin
                r_cnt_valid <= 1'b1;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (last_accept) begin
            r_s1_hits    <= cls_hits;
            r_s1_verdict <= cls_verdict;
            r_s1_fwd     <= cnt_wr;
            r_s1_zero    <= !r_cnt_valid && !cnt_wr;
        end
        if (cnt_wr) begin
            r_wr_data  <= cnt_new;
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks on the counter pipeline and the parse state.
    `PHCC_ASSERT_NEXT(a_s1_holds, r_s1_valid && r_out_valid && !i_m_tready, r_s1_valid,
        "counter stage lost a result while the output was stalled")
    `PHCC_ASSERT_NOW(a_src_unique, r_s1_valid, !(r_s1_fwd && r_s1_zero),
        "counter stage selects both forwarded and reset counts")
    `PHCC_ASSERT_NEXT(a_frame_restart, last_accept, (r_pos == 8'd0) && (r_tags == '0),
        "parse state not cleared after a last byte")
    `PHCC_ASSERT_NOW(a_ip_start_bound, 1'b1, r_ip_start <= IPS_LIMIT,
        "IP header start moved past the last allowed tag")

endmodule

// File: hdl/phcc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module phcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [0:(2**AW)-1];
    logic [WIDTH-1:0] r_rd_data;

    // Read returns the old contents when both ports hit the same entry.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: bench/packet_header_classifier_counter_tb.sv
// Self-checking testbench of the packet header classifier counter.
`timescale 1ns / 1ps

module packet_header_classifier_counter_tb;
    import phcc_pkg::*;

    localparam int TAG_LIMIT     = MAX_TAGS_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 5;
    localparam int PHASE_BYTES   = 260;
    localparam int PHASE_FRAMES  = 4;
    localparam logic [15:0] ETH_P_IPV4 = 16'h0800;

    // Expected result of one frame, laid out like the output data.
    typedef struct packed {
        logic [NUM_CLASSES-1:0][CNT_OUT_W-1:0] counts;
        t_hits                                 hits;
        logic                                  verdict;
    } t_verdict;

    // Tracks the parse of the frame in flight and holds the verdicts still owed.
    class header_class_tracker;
        logic                 drop_parity;
        logic [CNT_OUT_W-1:0] class_tally [NUM_CLASSES];
        t_verdict             pending [$];
        int unsigned          errors;
        int unsigned          results_seen;
        int unsigned          drops;
        int unsigned          class_hits [NUM_CLASSES];

        // Parse state of the current frame.
        logic [7:0]  byte_pos;
        logic [15:0] eth_type;
        logic [15:0] next_type;
        logic [7:0]  type_hi;
        logic [1:0]  tag_depth;
        logic [4:0]  ip_base;
        logic [3:0]  ip_words;
        logic [3:0]  tcp_words;
        logic [7:0]  ip_proto;
        logic [63:0] l4_head;

        function new();
            drop_parity  = 1'b0;
            errors       = 0;
            results_seen = 0;
            drops        = 0;
            foreach (class_tally[c]) begin
                class_tally[c] = '0;
                class_hits[c]  = 0;
            end
            restart_frame();
        endfunction

        function void restart_frame();
            byte_pos  = '0;
            eth_type  = '0;
            next_type = '0;
            type_hi   = '0;
            tag_depth = '0;
            ip_base   = 5'(ETH_LEN);
            ip_words  = '0;
            tcp_words = '0;
            ip_proto  = '0;
            l4_head   = '0;
        endfunction

        function logic is_tag_tpid(logic [15:0] t);
            return (t == TPID_CTAG) || (t == TPID_STAG);
        endfunction

        function void flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endfunction

        // Folds one frame byte at position p into the parse state.
        function void absorb(logic [7:0] p, logic [7:0] b);
            int rel;
            int l4_at;
            int k;
            if (p == ETH_TYPE_HI) begin
                eth_type = {b, 8'h00};
            end else if (p == ETH_TYPE_LO) begin
                eth_type[7:0] = b;
                next_type = {eth_type[15:8], b};
            end else if (p >= ip_base) begin
                rel = int'(p) - int'(ip_base);
                // A tag is taken while the chain still names a tag type and room is left.
                if (rel < VLAN_LEN && tag_depth < TAG_LIMIT && is_tag_tpid(next_type)) begin
                    if (rel == 2) begin
                        type_hi = b;
                    end else if (rel == 3) begin
                        next_type = {type_hi, b};
                        tag_depth++;
                        ip_base += 5'(VLAN_LEN);
                    end
                    return;
                end
                if (rel == 0)
                    ip_words = b[3:0];
                else if (rel == IP_PROTO_OFS)
                    ip_proto = b;
                if (ip_words >= HDR_WORDS_MIN) begin
                    l4_at = int'(ip_base) + 4 * int'(ip_words);
                    if (int'(p) >= l4_at) begin
                        k = int'(p) - l4_at;
                        if (k < L4_KEEP)
                            l4_head[8*k +: 8] = l4_head[8*k +: 8] | b;
                        else if (k == TCP_OFS_POS)
                            tcp_words = b[7:4];
                    end
                end
            end
        endfunction

        // Notes one accepted byte request; the last byte of a frame owes a verdict.
        function void note_request(logic [7:0] b, logic last);
            logic [7:0]             p;
            logic [NUM_CLASSES-1:0] hit_vec;
            int                     len;
            int                     l4_at;
            t_verdict               v;
            p = byte_pos;
            absorb(p, b);
            if (byte_pos != 8'hFF)
                byte_pos++;
            if (!last)
                return;

            len = int'(p) + 1;
            v = '0;
            v.verdict = VERDICT_PASS;
            v.hits.vlan = (len >= ETH_LEN) && is_tag_tpid(eth_type);
            l4_at = int'(ip_base) + 4 * int'(ip_words);
            if (len >= int'(ip_base) + IP_MIN_LEN && ip_words >= HDR_WORDS_MIN && len >= l4_at)
            begin
                if (ip_proto == PROTO_ICMP) begin
                    v.hits.ipv4 = 1'b1;
                    if (len >= l4_at + L4_KEEP && l4_head[7:0] == ICMP_PING_TYPE) begin
                        v.hits.icmp = 1'b1;
                        // The low bit of the echo sequence number picks the verdict.
                        if (l4_head[56] == drop_parity)
                            v.verdict = VERDICT_DROP;
                    end
                end else if (ip_proto == PROTO_UDP) begin
                    v.hits.ipv4 = 1'b1;
                    if (len >= l4_at + L4_KEEP && {l4_head[39:32], l4_head[47:40]} >= 16'd8)
                        v.hits.udp = 1'b1;
                end else if (ip_proto == PROTO_TCP) begin
                    v.hits.ipv4 = 1'b1;
                    if (len >= l4_at + TCP_MIN_LEN && tcp_words >= HDR_WORDS_MIN &&
                        len >= l4_at + 4 * int'(tcp_words))
                        v.hits.tcp = 1'b1;
                end
            end

            // Bump the wrapping counters of every class this frame hit.
            hit_vec = v.hits;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (hit_vec[c]) begin
                    class_tally[c] = class_tally[c] + CNT_OUT_W'(1);
                    class_hits[c]++;
                end
                v.counts[c] = class_tally[c];
            end
            if (v.verdict == VERDICT_DROP)
                drops++;
            pending.push_back(v);
            restart_frame();
        endfunction

        // Compares one accepted result request with the oldest owed verdict.
        function void check_result(logic [OUT_TDATA_W-1:0] d);
            t_verdict               want;
            logic [NUM_CLASSES-1:0] got_hits;
            logic [NUM_CLASSES-1:0] want_hits;
            logic [CNT_OUT_W-1:0]   got_count;
            string                  class_name [NUM_CLASSES];
            class_name = '{"vlan", "ipv4", "icmp", "udp", "tcp"};
            if (pending.size() == 0) begin
                flag_mismatch($sformatf("result %0d arrived with no frame pending",
                                        results_seen));
                results_seen++;
                return;
            end
            want = pending.pop_front();
            if (d[0] !== want.verdict)
                flag_mismatch($sformatf("result %0d verdict got %0b want %0b",
                                        results_seen, d[0], want.verdict));
            got_hits  = d[OUT_FLAG_W-1:1];
            want_hits = want.hits;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                got_count = d[OUT_FLAG_W + CNT_OUT_W*c +: CNT_OUT_W];
                if (got_hits[c] !== want_hits[c])
                    flag_mismatch($sformatf("result %0d hit_%s got %0b want %0b",
                                            results_seen, class_name[c], got_hits[c],
                                            want_hits[c]));
                if (got_count !== want.counts[c])
                    flag_mismatch($sformatf("result %0d %s_count got %0d want %0d",
                                            results_seen, class_name[c], got_count,
                                            want.counts[c]));
            end
            results_seen++;
        endfunction
    endclass

    // Clock, reset and block inputs, all known from time zero.
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   i_s_tlast  = 1'b0;
    logic                   i_m_tready = 1'b1;
    logic                   psel       = 1'b0;
    logic                   penable    = 1'b0;
    logic                   pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr      = '0;
    logic [APB_DATA_W-1:0]  pwdata     = '0;

    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    header_class_tracker sb = new();

    logic [7:0]  frame_q [$];
    int unsigned bytes_sent       = 0;
    int unsigned frames_sent      = 0;
    int unsigned settings_written = 0;
    int          src_gap_pct      = 0;
    int          sink_stall_pct   = 0;

    packet_header_classifier_counter #(
        .MAX_TAGS   (MAX_TAGS_DEF),
        .COUNT_BITS (COUNT_BITS_DEF)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #6 i_clk = ~i_clk;

    // Result sink: checks every accepted result request and stalls in random bursts.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready)
                sb.check_result(o_m_tdata);
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                i_m_tready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[%0t] timeout after %0d cycles", $time, cycles);
        $display("packet_header_classifier_counter regression: fail");
        $finish;
    end

    task automatic push_random(input int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    // Sends one byte request, after an optional gap with junk on the data lines.
    task automatic push_byte(input logic [7:0] b, input logic last);
        if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom);
            i_s_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        sb.note_request(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            push_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // Writes the drop parity register through a setup and an access cycle.
    task automatic write_parity(input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_DROP_PARITY;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.drop_parity = value[0];
        settings_written++;
    endtask

    // Lets the block drain the owed verdicts, bounded by DRAIN_LIMIT, then waits out SETTLE_CYCLES.
    task automatic settle();
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (sb.pending.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Builds one frame: mostly well-formed headers with random content, some noise.
    task automatic build_frame();
        int          pick;
        int          ntags;
        int          ihl;
        int          tcp_len_words;
        int          cut;
        int          pad_to;
        logic [7:0]  proto;
        logic [15:0] etype;
        logic [15:0] udp_len;
        frame_q.delete();
        pick = $urandom_range(0, 99);

        // Unstructured bytes, now and then with a tag type where the EtherType sits.
        if (pick < 10) begin
            push_random($urandom_range(1, 40));
            if (frame_q.size() >= ETH_LEN && $urandom_range(0, 1)) begin
                frame_q[ETH_TYPE_HI] = TPID_CTAG[15:8];
                frame_q[ETH_TYPE_LO] = TPID_CTAG[7:0];
            end
            return;
        end

        // Addresses, then the EtherType chain through zero to three tags.
        push_random(12);
        pick  = $urandom_range(0, 9);
        ntags = (pick < 4) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
        for (int t = 0; t <= ntags; t++) begin
            if (t > 0)
                push_random(2);
            if (t < ntags)
                etype = $urandom_range(0, 1) ? TPID_CTAG : TPID_STAG;
            else
                etype = ($urandom_range(0, 3) != 0) ? ETH_P_IPV4 : 16'($urandom);
            frame_q.push_back(etype[15:8]);
            frame_q.push_back(etype[7:0]);
        end

        // IPv4 header, with a header length that is sometimes out of range.
        pick = $urandom_range(0, 19);
        ihl  = (pick < 14) ? 5 : (pick < 17) ? $urandom_range(6, 8) :
               (pick < 19) ? $urandom_range(0, 4) : $urandom_range(9, 15);
        pick  = $urandom_range(0, 9);
        proto = (pick < 3) ? PROTO_ICMP : (pick < 6) ? PROTO_UDP :
                (pick < 9) ? PROTO_TCP : 8'($urandom);
        frame_q.push_back({($urandom_range(0, 7) != 0) ? 4'h4 : 4'($urandom), 4'(ihl)});
        push_random(8);
        frame_q.push_back(proto);
        push_random(10);
        if (ihl > 5)
            push_random(4 * ihl - IP_MIN_LEN);

        // Transport header.
        if (proto == PROTO_ICMP) begin
            frame_q.push_back(($urandom_range(0, 4) != 0) ? ICMP_PING_TYPE : 8'($urandom));
            push_random(7);
        end else if (proto == PROTO_UDP) begin
            pick    = $urandom_range(0, 9);
            udp_len = (pick < 2) ? 16'($urandom_range(0, 7)) : (pick < 3) ? 16'd8 :
                      16'($urandom_range(9, 65535));
            push_random(4);
            frame_q.push_back(udp_len[15:8]);
            frame_q.push_back(udp_len[7:0]);
            push_random(2);
        end else if (proto == PROTO_TCP) begin
            pick = $urandom_range(0, 19);
            tcp_len_words = (pick < 15) ? $urandom_range(5, 8) :
                            (pick < 17) ? $urandom_range(0, 4) : $urandom_range(9, 15);
            push_random(12);
            frame_q.push_back({4'(tcp_len_words), 4'($urandom)});
            push_random(7);
            if (tcp_len_words > 5)
                push_random(4 * tcp_len_words - TCP_MIN_LEN);
        end else begin
            push_random(8);
        end
        push_random($urandom_range(0, 12));

        // A rare long frame may run past the point where the byte position saturates.
        if ($urandom_range(0, 29) == 0) begin
            pad_to = $urandom_range(250, 300);
            while (frame_q.size() < pad_to)
                push_random(1);
        end
        // Some frames end early, inside one of their headers.
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
    endtask

    // Main sequence: reset, a short directed part, then phases of random frames.
    initial begin
        logic [APB_DATA_W-1:0] parity_value [PHASES];
        int                    src_pct [PHASES];
        int                    sink_pct [PHASES];
        int unsigned           start_bytes;
        int unsigned           start_frames;
        parity_value = '{32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0000_0000};
        parity_value[3] = $urandom;
        src_pct  = '{25, 0, 10, 40, 0};
        sink_pct = '{20, 35, 0, 15, 0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Parity zero with every upper register bit set.
        write_parity(32'hFFFF_FFFE);

        // Shortest possible frame.
        frame_q = '{8'h00};
        send_frame();
        // Frame that ends before the EtherType.
        frame_q.delete();
        repeat (8) frame_q.push_back(8'hFF);
        send_frame();
        // Frame of exactly one Ethernet header with a tag type.
        frame_q.delete();
        repeat (6) begin
            frame_q.push_back(8'hFF);
            frame_q.push_back(8'h00);
        end
        frame_q.push_back(TPID_CTAG[15:8]);
        frame_q.push_back(TPID_CTAG[7:0]);
        send_frame();
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_parity(parity_value[ph]);
            src_gap_pct    = src_pct[ph];
            sink_stall_pct = sink_pct[ph];
            start_bytes    = bytes_sent;
            start_frames   = frames_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES ||
                   frames_sent - start_frames < PHASE_FRAMES) begin
                build_frame();
                send_frame();
            end
            settle();
        end

        if (sb.pending.size() != 0)
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending.size()));

        $display("Run covered %0d frames in %0d byte requests over %0d parity writes.",
                 frames_sent, bytes_sent, settings_written);
        $display("Class hits: vlan %0d, ipv4 %0d, icmp echo %0d, udp %0d, tcp %0d; %0d dropped.",
                 sb.class_hits[0], sb.class_hits[1], sb.class_hits[2], sb.class_hits[3],
                 sb.class_hits[4], sb.drops);
        if (sb.errors == 0) begin
            $display("packet_header_classifier_counter regression: pass");
        end else begin
            $display("packet_header_classifier_counter regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/phcc_pkg.sv
hdl/phcc_ram.sv
hdl/packet_header_classifier_counter.sv
bench/packet_header_classifier_counter_tb.sv
